// File: rtl/bsfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_pkg
// Shared constants, command word type and stuffing helpers for the
// byte-stuffing frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

	localparam logic [7:0] FLAG_BYTE     = 8'h7E;
	localparam logic [7:0] ESC_BYTE      = 8'h7F;
	localparam logic [7:0] ESC_FLAG      = 8'h80;
	localparam logic [7:0] ESC_ESC       = 8'h81;
	localparam logic [7:0] TARGET_RESET  = 8'h55;

	// One classified input word, as handed from front to back.
	typedef struct packed {
		logic       open;      // emit opening flag first
		logic       has_data;  // emit stuffed payload byte
		logic [7:0] data;
		logic       close;     // emit stuffed checksum and closing flag
		logic [7:0] chk;
	} cmd_t;

	function automatic logic needs_esc(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	function automatic logic [7:0] esc_code(input logic [7:0] b);
		return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bsfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts input words, tracks frame state and running sum, and turns each
// word into a command for the back end.
// ----------------------------------------------------------------------------
module bsfb_front
	import bsfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] payload_byte,
	input  wire logic       final_byte,
	input  wire logic       empty_frame,
	input  wire logic       q_full,
	output logic            q_push,
	output cmd_t            q_wdata
);

	logic       inside_q;
	logic [7:0] sum_q;
	logic [7:0] target_q;

	logic [7:0] base_sum;
	logic [7:0] sum_new;
	logic       close;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		base_sum = inside_q ? sum_q : 8'h00;
		sum_new  = empty_frame ? base_sum : 8'(base_sum + payload_byte);
		close    = empty_frame || final_byte;

		q_wdata.open     = !inside_q;
		q_wdata.has_data = !empty_frame;
		q_wdata.data     = payload_byte;
		q_wdata.close    = close;
		q_wdata.chk      = 8'(target_q - sum_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			sum_q    <= 8'h00;
			target_q <= TARGET_RESET;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (q_push) begin
				inside_q <= !close;
				sum_q    <= close ? 8'h00 : sum_new;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/bsfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module bsfb_queue
	import bsfb_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output logic      rvalid,
	output cmd_t      rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	assign full   = (count_q == CW'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/bsfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsfb_back
// Expands one command into its frame bytes, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module bsfb_back
	import bsfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire cmd_t       q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      frame_byte,
	output logic            run_last,
	output logic            frame_closed
);

	// pending work for the command in hand
	logic       open_q, esc_q, data_q, chk_q, close_q;
	logic [7:0] esc_byte_q, data_byte_q, chk_byte_q;

	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       run_last_q, frame_closed_q;

	logic       busy, emit, last;
	logic       n_open, n_esc, n_data, n_chk, n_close;
	logic [7:0] n_esc_byte, e_byte;
	logic       e_closed;

	assign busy = open_q || esc_q || data_q || chk_q || close_q;
	assign emit = busy && (!out_valid_q || out_ready);

	// pick the next byte in frame order
	always_comb begin
		n_open     = open_q;
		n_esc      = esc_q;
		n_data     = data_q;
		n_chk      = chk_q;
		n_close    = close_q;
		n_esc_byte = esc_byte_q;
		e_byte     = FLAG_BYTE;
		e_closed   = 1'b0;
		if (open_q) begin
			n_open = 1'b0;
		end else if (esc_q) begin
			e_byte = esc_byte_q;
			n_esc  = 1'b0;
		end else if (data_q) begin
			n_data = 1'b0;
			if (needs_esc(data_byte_q)) begin
				e_byte     = ESC_BYTE;
				n_esc      = 1'b1;
				n_esc_byte = esc_code(data_byte_q);
			end else begin
				e_byte = data_byte_q;
			end
		end else if (chk_q) begin
			n_chk = 1'b0;
			if (needs_esc(chk_byte_q)) begin
				e_byte     = ESC_BYTE;
				n_esc      = 1'b1;
				n_esc_byte = esc_code(chk_byte_q);
			end else begin
				e_byte = chk_byte_q;
			end
		end else begin
			n_close  = 1'b0;
			e_closed = 1'b1;
		end
		last = !(n_open || n_esc || n_data || n_chk || n_close);
	end

	assign q_pop = q_valid && (!busy || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			esc_q       <= 1'b0;
			data_q      <= 1'b0;
			chk_q       <= 1'b0;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				open_q  <= q_rdata.open;
				esc_q   <= 1'b0;
				data_q  <= q_rdata.has_data;
				chk_q   <= q_rdata.close;
				close_q <= q_rdata.close;
			end else if (emit) begin
				open_q  <= n_open;
				esc_q   <= n_esc;
				data_q  <= n_data;
				chk_q   <= n_chk;
				close_q <= n_close;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_byte_q <= q_rdata.data;
			chk_byte_q  <= q_rdata.chk;
		end
		if (emit) begin
			esc_byte_q     <= n_esc_byte;
			frame_byte_q   <= e_byte;
			run_last_q     <= last;
			frame_closed_q <= e_closed;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = frame_byte_q;
	assign run_last     = run_last_q;
	assign frame_closed = frame_closed_q;

endmodule
`default_nettype wire

// File: rtl/byte_stuff_frame_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuff_frame_builder
// Byte-stuffing framer with additive checksum: opening flag, stuffed payload,
// stuffed checksum and closing flag.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   input   | in_valid / in_ready    | payload_byte, final_byte, empty_frame
//   output  | out_valid / out_ready  | frame_byte, run_last, frame_closed
//   config  | cfg_we                 | cfg_wdata (checksum_target)
//
// The back end sends one frame byte per cycle while the output is not stalled;
// a word makes 1 to 6 bytes, so a plain mid-frame byte moves every cycle.
// Each word passes the command queue, back end state and output register.
// The command queue (QUEUE_DEPTH words) lets the front keep accepting while
// the output is stalled. Reset clears frame state and sets the target to 0x55.
// ----------------------------------------------------------------------------
module byte_stuff_frame_builder
	import bsfb_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] payload_byte,
	input  wire logic       final_byte,
	input  wire logic       empty_frame,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      frame_byte,
	output logic            run_last,
	output logic            frame_closed
);

	logic q_push, q_full, q_pop, q_valid;
	cmd_t q_wdata, q_rdata;

	bsfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.final_byte   (final_byte),
		.empty_frame  (empty_frame),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	bsfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	bsfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.run_last     (run_last),
		.frame_closed (frame_closed)
	);

	// closing flag always ends the run of its word
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_closed |-> run_last && (frame_byte == FLAG_BYTE))
		else $error("closing flag not last or not 0x7E");

	// a pushed word is still queued on the next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> q_valid)
		else $error("queue lost a word");

	// no pop from an empty queue, no push into a full one
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && !q_valid) && !(q_push && q_full))
		else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// File: tb/frame_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stream_checker
// Watches the input and output channels of the frame builder. Each accepted
// input word is turned into the frame bytes it should produce, and every
// accepted output byte is compared against the oldest of them.
// ----------------------------------------------------------------------------
module frame_stream_checker
	import bsfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] payload_byte,
	input  wire logic       final_byte,
	input  wire logic       empty_frame,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] frame_byte,
	input  wire logic       run_last,
	input  wire logic       frame_closed,
	output int              fail_total,
	output int              outstanding,
	output int              bytes_seen,
	output int              closes_seen
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       closing;
	} frame_word_t;

	frame_word_t expected_frame_bytes[$];
	frame_word_t oldest;

	logic [7:0] checksum_target;
	logic       frame_open;
	logic [7:0] payload_sum;
	int         mismatches;
	int         checked;
	int         closed;

	function automatic void push_frame_byte(input logic [7:0] v, input logic closing);
		frame_word_t w;
		w.value = v;
		w.last = 1'b0;
		w.closing = closing;
		expected_frame_bytes.push_back(w);
	endfunction

	// flag and escape bytes go out as an escape pair
	function automatic void push_escaped(input logic [7:0] v);
		if (v == FLAG_BYTE) begin
			push_frame_byte(ESC_BYTE, 1'b0);
			push_frame_byte(ESC_FLAG, 1'b0);
		end else if (v == ESC_BYTE) begin
			push_frame_byte(ESC_BYTE, 1'b0);
			push_frame_byte(ESC_ESC, 1'b0);
		end else begin
			push_frame_byte(v, 1'b0);
		end
	endfunction

	function automatic void predict_frame_bytes(input logic [7:0] data, input logic last,
			input logic empty);
		logic [7:0]  check;
		frame_word_t tail;
		if (!frame_open) begin
			push_frame_byte(FLAG_BYTE, 1'b0);
			frame_open = 1'b1;
			payload_sum = 8'h00;
		end
		if (!empty) begin
			push_escaped(data);
			payload_sum = payload_sum + data;
		end
		// empty mark closes an open frame without adding its byte
		if (empty || last) begin
			check = checksum_target - payload_sum;
			push_escaped(check);
			push_frame_byte(FLAG_BYTE, 1'b1);
			frame_open = 1'b0;
			payload_sum = 8'h00;
		end
		tail = expected_frame_bytes.pop_back();
		tail.last = 1'b1;
		expected_frame_bytes.push_back(tail);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_frame_bytes.delete();
			checksum_target = TARGET_RESET;
			frame_open = 1'b0;
			payload_sum = 8'h00;
			mismatches = 0;
			checked = 0;
			closed = 0;
			fail_total <= 0;
			outstanding <= 0;
			bytes_seen <= 0;
			closes_seen <= 0;
		end else begin
			if (cfg_we)
				checksum_target = cfg_wdata;
			if (in_valid && in_ready)
				predict_frame_bytes(payload_byte, final_byte, empty_frame);
			if (out_valid && out_ready) begin
				if (expected_frame_bytes.size() == 0) begin
					$error("unexpected frame byte %02h (run_last %0b, frame_closed %0b)",
						frame_byte, run_last, frame_closed);
					mismatches++;
				end else begin
					oldest = expected_frame_bytes.pop_front();
					checked++;
					if (oldest.closing)
						closed++;
					if (frame_byte !== oldest.value) begin
						$error("frame_byte mismatch: expected %02h, got %02h",
							oldest.value, frame_byte);
						mismatches++;
					end
					if (run_last !== oldest.last) begin
						$error("run_last mismatch: expected %0b, got %0b",
							oldest.last, run_last);
						mismatches++;
					end
					if (frame_closed !== oldest.closing) begin
						$error("frame_closed mismatch: expected %0b, got %0b",
							oldest.closing, frame_closed);
						mismatches++;
					end
				end
			end
			fail_total <= mismatches;
			outstanding <= expected_frame_bytes.size();
			bytes_seen <= checked;
			closes_seen <= closed;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the byte-stuffing frame builder: directed frames
// around flag/escape bytes and checksum stuffing, then random frames under
// several checksum targets with random idling, a long output hold and drains.
// ----------------------------------------------------------------------------
module tb;
	import bsfb_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_CYCLES     = 80;
	localparam int IDLE_PCT        = 17;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int END_WAIT        = 20000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic [7:0] payload_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty_frame = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] frame_byte;
	logic       run_last;
	logic       frame_closed;

	int fail_total;
	int outstanding;
	int bytes_seen;
	int closes_seen;

	int   cycle_count = 0;
	int   words_sent = 0;
	int   targets_used = 1;
	logic steady = 1'b0;
	int   hold_req = 0;
	int   hold_done = 0;
	int   hold_left = 0;

	always #4 clk = ~clk;

	byte_stuff_frame_builder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.final_byte   (final_byte),
		.empty_frame  (empty_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.run_last     (run_last),
		.frame_closed (frame_closed)
	);

	frame_stream_checker frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.final_byte   (final_byte),
		.empty_frame  (empty_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.run_last     (run_last),
		.frame_closed (frame_closed),
		.fail_total   (fail_total),
		.outstanding  (outstanding),
		.bytes_seen   (bytes_seen),
		.closes_seen  (closes_seen)
	);

	// receiver: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic fin, input logic emp);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		payload_byte <= b;
		final_byte <= fin;
		empty_frame <= emp;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_target(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		targets_used++;
	endtask

	// lean toward flag and escape bytes so stuffing shows up often
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return FLAG_BYTE;
		if (r < 24)
			return ESC_BYTE;
		if (r < 30)
			return $urandom_range(1) ? ESC_FLAG : ESC_ESC;
		return 8'($urandom_range(255));
	endfunction

	task automatic random_traffic(input int n);
		int   sent_here;
		int   r;
		int   len;
		logic mark;
		sent_here = 0;
		while (sent_here < n) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_word(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent_here++;
			end else if (r < 18) begin
				send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
				sent_here++;
			end else begin
				len = $urandom_range(1, 8);
				mark = ($urandom_range(99) < 15);
				for (int i = 0; i < len; i++)
					send_word(pick_byte(), !mark && (i == len - 1), 1'b0);
				// some frames are closed by an empty mark instead of final_byte
				if (mark)
					send_word(pick_byte(), 1'($urandom_range(1)), 1'b1);
				sent_here += len + int'(mark);
			end
		end
	endtask

	initial begin
		logic [7:0] tgt;
		int         wait_left;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset target 0x55
		send_word(8'hA5, 1'b1, 1'b1);   // empty frame from idle, final ignored
		send_word(8'h00, 1'b0, 1'b1);   // empty frame, final low
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(FLAG_BYTE, 1'b0, 1'b0);
		send_word(ESC_BYTE, 1'b0, 1'b0);
		send_word(ESC_FLAG, 1'b0, 1'b0);
		send_word(ESC_ESC, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hD7, 1'b1, 1'b0);   // checksum comes out as 0x7E
		send_word(8'hD6, 1'b1, 1'b0);   // checksum comes out as 0x7F
		send_word(8'h12, 1'b0, 1'b0);
		send_word(FLAG_BYTE, 1'b0, 1'b1); // empty mark closes the open frame
		send_word(FLAG_BYTE, 1'b1, 1'b0);
		drain();

		// 0xFD lets a stuffed payload byte and a stuffed checksum share a word
		write_target(8'hFD);
		send_word(FLAG_BYTE, 1'b1, 1'b0);
		send_word(8'h10, 1'b0, 1'b1);
		send_word(ESC_BYTE, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(ESC_BYTE, 1'b1, 1'b0);
		drain();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: tgt = 8'h00;
				1: tgt = 8'hFF;
				3: tgt = FLAG_BYTE;
				default: tgt = 8'($urandom_range(255));
			endcase
			write_target(tgt);
			if (p == 2) begin
				// no idling, and the output held long enough to back up the input
				steady <= 1'b1;
				hold_req <= hold_req + 1;
				random_traffic(40);
				steady <= 1'b0;
				random_traffic(ITEMS_PER_PHASE - 40);
			end else if (p == 3) begin
				random_traffic(ITEMS_PER_PHASE / 2);
				drain();
				random_traffic(ITEMS_PER_PHASE / 2);
			end else begin
				random_traffic(ITEMS_PER_PHASE);
			end
			if (p < 4)
				drain();
		end

		in_valid <= 1'b0;
		wait_left = END_WAIT;
		do begin
			@(posedge clk);
			wait_left--;
		end while (outstanding != 0 && wait_left > 0);
		repeat (8) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected frame bytes never arrived", outstanding);

		$display("Sent %0d input words under %0d checksum targets, one long output hold.",
			words_sent, targets_used);
		$display("Compared %0d frame bytes across %0d closed frames.", bytes_seen, closes_seen);
		if (fail_total == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
